[src/tcw_pkg.sv]
// Shared types, codes and constants for the text console writer.
package tcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 11;
    localparam int POS_W   = 11;
    localparam int CELL_W  = 16;

    // Special bytes and cell values
    localparam logic [BYTE_W-1:0] CHAR_NL    = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h0F;
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd_code;

    // Input word
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [BYTE_W-1:0]  char_code;
        logic [INDEX_W-1:0] cell_index;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [BYTE_W-1:0] cell_glyph;
        logic [BYTE_W-1:0] cell_attr;
        logic [POS_W-1:0]  cursor_pos;
        logic              printed;
    } t_out_word;

    // Screen memory operations
    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_FILL,   // write blank at sweep pointer
        MEM_ZERO,   // write zero at sweep pointer
        MEM_COPY,   // read one row below sweep pointer, write back next cycle
        MEM_CHAR,   // write glyph and attribute at cursor
        MEM_READ,   // read cell at latched index
        MEM_RZERO   // read data register to zero
    } t_mem_op;

    // Cursor operations
    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_HOME,
        CUR_NEWLINE,
        CUR_CLAMP,
        CUR_ADVANCE
    } t_cur_op;

    // Controller commands to datapath
    typedef struct packed {
        logic    latch;
        logic    ptr_inc;
        logic    ptr_clr;
        t_mem_op mem_op;
        t_cur_op cur_op;
    } t_dp_ctl;

    // Datapath status to controller
    typedef struct packed {
        t_cmd_code cmd;
        logic      is_nl;
        logic      is_cr;
        logic      idx_ok;
        logic      wrap_pend;
        logic      base_at_last;
        logic      ptr_fill_end;
        logic      ptr_copy_end;
    } t_dp_stat;

    // Controller states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_COPY,
        S_DRAIN,
        S_ZERO,
        S_WRITE,
        S_CLEAR,
        S_DONE
    } t_state;

endpackage

[src/tcw_ctrl.sv]
// Controller state machine sequencing commands, scrolls and screen sweeps.
module tcw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output logic             o_strobe,
    input  tcw_pkg::t_dp_stat i_stat,
    output tcw_pkg::t_dp_ctl  o_ctl
);

    tcw_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state        = r_state;
        o_ctl.latch    = 1'b0;
        o_ctl.ptr_inc  = 1'b0;
        o_ctl.ptr_clr  = 1'b0;
        o_ctl.mem_op   = tcw_pkg::MEM_NONE;
        o_ctl.cur_op   = tcw_pkg::CUR_HOLD;
        busy           = 1'b1;
        o_strobe       = 1'b0;
        case (r_state)
            // clearing pass after reset
            tcw_pkg::S_INIT: begin
                o_ctl.mem_op = tcw_pkg::MEM_FILL;
                if (i_stat.ptr_fill_end) begin
                    o_ctl.ptr_clr = 1'b1;
                    n_state       = tcw_pkg::S_IDLE;
                end else begin
                    o_ctl.ptr_inc = 1'b1;
                end
            end
            tcw_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_ctl.latch = 1'b1;
                    n_state     = tcw_pkg::S_DECODE;
                end
            end
            tcw_pkg::S_DECODE: begin
                case (i_stat.cmd)
                    tcw_pkg::CMD_PUT: begin
                        if (i_stat.is_nl) begin
                            if (i_stat.base_at_last) begin
                                n_state = tcw_pkg::S_COPY;
                            end else begin
                                o_ctl.cur_op = tcw_pkg::CUR_NEWLINE;
                                n_state      = tcw_pkg::S_DONE;
                            end
                        end else if (i_stat.wrap_pend) begin
                            n_state = tcw_pkg::S_COPY;
                        end else if (i_stat.is_cr) begin
                            n_state = tcw_pkg::S_DONE;
                        end else begin
                            n_state = tcw_pkg::S_WRITE;
                        end
                    end
                    tcw_pkg::CMD_READ: begin
                        o_ctl.mem_op = i_stat.idx_ok ? tcw_pkg::MEM_READ
                                                     : tcw_pkg::MEM_RZERO;
                        n_state      = tcw_pkg::S_DONE;
                    end
                    tcw_pkg::CMD_CLEAR: begin
                        o_ctl.cur_op = tcw_pkg::CUR_HOME;
                        n_state      = tcw_pkg::S_CLEAR;
                    end
                    default: begin
                        n_state = tcw_pkg::S_DONE;
                    end
                endcase
            end
            // scroll: move rows up, one cell a cycle
            tcw_pkg::S_COPY: begin
                o_ctl.mem_op  = tcw_pkg::MEM_COPY;
                o_ctl.ptr_inc = 1'b1;
                if (i_stat.ptr_copy_end) begin
                    n_state = tcw_pkg::S_DRAIN;
                end
            end
            // last copied cell lands on the write port
            tcw_pkg::S_DRAIN: begin
                n_state = tcw_pkg::S_ZERO;
            end
            // scroll: zero the last row
            tcw_pkg::S_ZERO: begin
                o_ctl.mem_op = tcw_pkg::MEM_ZERO;
                if (i_stat.ptr_fill_end) begin
                    o_ctl.ptr_clr = 1'b1;
                    o_ctl.cur_op  = tcw_pkg::CUR_CLAMP;
                    if (i_stat.is_nl || i_stat.is_cr) begin
                        n_state = tcw_pkg::S_DONE;
                    end else begin
                        n_state = tcw_pkg::S_WRITE;
                    end
                end else begin
                    o_ctl.ptr_inc = 1'b1;
                end
            end
            tcw_pkg::S_WRITE: begin
                o_ctl.mem_op = tcw_pkg::MEM_CHAR;
                o_ctl.cur_op = tcw_pkg::CUR_ADVANCE;
                n_state      = tcw_pkg::S_DONE;
            end
            tcw_pkg::S_CLEAR: begin
                o_ctl.mem_op = tcw_pkg::MEM_FILL;
                if (i_stat.ptr_fill_end) begin
                    o_ctl.ptr_clr = 1'b1;
                    n_state       = tcw_pkg::S_DONE;
                end else begin
                    o_ctl.ptr_inc = 1'b1;
                end
            end
            tcw_pkg::S_DONE: begin
                o_strobe = 1'b1;
                n_state  = tcw_pkg::S_IDLE;
            end
            default: begin
                n_state = tcw_pkg::S_INIT;
            end
        endcase
    end

`ifndef SYNTHESIS
    // an accepted word is always decoded next
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == tcw_pkg::S_DECODE))
        else $error("accepted word not decoded");

    // one result per word, then ready again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> (!o_strobe && !busy))
        else $error("result strobe not followed by idle");
`endif

endmodule

[src/tcw_datapath.sv]
// Datapath: screen memory, cursor, sweep pointer, attribute and result word.
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcw_pkg::t_in_word  i_in,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data,
    input  tcw_pkg::t_dp_ctl   i_ctl,
    output tcw_pkg::t_dp_stat  o_stat,
    output tcw_pkg::t_out_word o_out
);

    localparam int CELLS     = ROWS * COLUMNS;
    localparam int LAST_BASE = CELLS - COLUMNS;
    localparam int AW        = $clog2(CELLS);
    localparam int CW        = $clog2(CELLS + 1);
    localparam int COL_W     = $clog2(COLUMNS);

    logic [tcw_pkg::CELL_W-1:0] mem [CELLS];

    tcw_pkg::t_in_word          r_in;
    logic [7:0]                 r_attr;
    logic [CW-1:0]              r_base, n_base;
    logic [COL_W-1:0]           r_col, n_col;
    logic [AW-1:0]              r_ptr;
    logic                       r_cp_pend;
    logic [AW-1:0]              r_cp_addr;
    logic [tcw_pkg::CELL_W-1:0] r_rd_data;

    logic [CW-1:0]              cursor;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [tcw_pkg::CELL_W-1:0] wr_data;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;

    assign cursor = r_base + CW'(r_col);

    // Latched command word and attribute register
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_data;
        end
    end

    // Cursor kept as row base plus column
    always_comb begin
        n_base = r_base;
        n_col  = r_col;
        case (i_ctl.cur_op)
            tcw_pkg::CUR_HOME: begin
                n_base = '0;
                n_col  = '0;
            end
            tcw_pkg::CUR_NEWLINE: begin
                n_base = r_base + CW'(COLUMNS);
                n_col  = '0;
            end
            tcw_pkg::CUR_CLAMP: begin
                n_base = CW'(LAST_BASE);
                n_col  = '0;
            end
            tcw_pkg::CUR_ADVANCE: begin
                if (r_col == COL_W'(COLUMNS - 1)) begin
                    n_base = r_base + CW'(COLUMNS);
                    n_col  = '0;
                end else begin
                    n_col  = r_col + 1'b1;
                end
            end
            default: begin
                n_base = r_base;
                n_col  = r_col;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_col  <= '0;
        end else begin
            r_base <= n_base;
            r_col  <= n_col;
        end
    end

    // Sweep pointer and pending copy write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_cp_pend <= 1'b0;
        end else begin
            if (i_ctl.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_ctl.ptr_inc) begin
                r_ptr <= r_ptr + 1'b1;
            end
            r_cp_pend <= (i_ctl.mem_op == tcw_pkg::MEM_COPY);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr <= r_ptr;
    end

    // Memory port selection; a pending copy write owns the write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ptr;
        wr_data = '0;
        if (r_cp_pend) begin
            wr_en   = 1'b1;
            wr_addr = r_cp_addr;
            wr_data = r_rd_data;
        end else begin
            case (i_ctl.mem_op)
                tcw_pkg::MEM_FILL: begin
                    wr_en   = 1'b1;
                    wr_data = tcw_pkg::BLANK_CELL;
                end
                tcw_pkg::MEM_ZERO: begin
                    wr_en   = 1'b1;
                end
                tcw_pkg::MEM_CHAR: begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(cursor);
                    wr_data = {r_attr, r_in.char_code};
                end
                default: begin
                    wr_en   = 1'b0;
                end
            endcase
        end
    end

    assign rd_en   = (i_ctl.mem_op == tcw_pkg::MEM_COPY) ||
                     (i_ctl.mem_op == tcw_pkg::MEM_READ);
    assign rd_addr = (i_ctl.mem_op == tcw_pkg::MEM_COPY) ? (r_ptr + AW'(COLUMNS))
                                                         : AW'(r_in.cell_index);

    // Screen memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end else if (i_ctl.mem_op == tcw_pkg::MEM_RZERO) begin
            r_rd_data <= '0;
        end
    end

    // Status to controller
    assign o_stat.cmd          = tcw_pkg::t_cmd_code'(r_in.cmd);
    assign o_stat.is_nl        = (r_in.char_code == tcw_pkg::CHAR_NL);
    assign o_stat.is_cr        = (r_in.char_code == tcw_pkg::CHAR_CR);
    assign o_stat.idx_ok       = (32'(r_in.cell_index) < 32'(CELLS));
    assign o_stat.wrap_pend    = (r_base == CW'(CELLS));
    assign o_stat.base_at_last = (r_base >= CW'(LAST_BASE));
    assign o_stat.ptr_fill_end = (r_ptr == AW'(CELLS - 1));
    assign o_stat.ptr_copy_end = (r_ptr == AW'(LAST_BASE - 1));

    // Result word
    always_comb begin
        o_out.cell_glyph = '0;
        o_out.cell_attr  = '0;
        if (o_stat.cmd == tcw_pkg::CMD_READ) begin
            o_out.cell_glyph = r_rd_data[7:0];
            o_out.cell_attr  = r_rd_data[15:8];
        end
        o_out.cursor_pos = tcw_pkg::POS_W'(cursor);
        o_out.printed    = !((o_stat.cmd == tcw_pkg::CMD_PUT) && o_stat.is_cr);
    end

`ifndef SYNTHESIS
    // column stays inside the row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= COL_W'(COLUMNS - 1)))
        else $error("cursor column out of range");

    // a pending wrap sits at column zero
    a_wrap_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_base == CW'(CELLS)) |-> (r_col == '0))
        else $error("wrap pending with nonzero column");

    // copy write back never meets another write
    a_wr_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_pend |-> (i_ctl.mem_op != tcw_pkg::MEM_FILL &&
                       i_ctl.mem_op != tcw_pkg::MEM_ZERO &&
                       i_ctl.mem_op != tcw_pkg::MEM_CHAR))
        else $error("screen write port conflict");
`endif

endmodule

[src/text_console_writer.sv]
// Top level of the text console writer: controller plus datapath.
//
// A word is taken when start is high and busy is low; its one result appears on
// o_out for a single cycle with o_strobe, and must be captured then. A plain
// character passes through decode and write before the strobe; a newline, carriage
// return or read goes from decode straight to the strobe. A put that scrolls first
// moves every row up one and zeroes the last row, and clear blanks the whole screen,
// because the screen memory has one write port and is swept one cell per cycle.
// After reset the block runs a clearing pass over every cell with busy high;
// attribute writes are taken at any time.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tcw_pkg::t_in_word  i_in,
    output logic               o_strobe,
    output tcw_pkg::t_out_word o_out,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data
);

    tcw_pkg::t_dp_ctl  ctl;
    tcw_pkg::t_dp_stat stat;

    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .i_stat   (stat),
        .o_ctl    (ctl)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (ctl),
        .o_stat     (stat),
        .o_out      (o_out)
    );

endmodule

[dv/text_console_writer_tb.sv]
// Self-checking testbench for the text console writer: directed table, then random bursts.
module testbench;

    localparam int COLS      = tcw_pkg::COLUMNS_DEF;
    localparam int NROWS     = tcw_pkg::ROWS_DEF;
    localparam int CELLS     = COLS * NROWS;
    localparam int RAND_WORDS = 700;
    // slowest run: ~820 words, each a full sweep plus the longest gap, taken 4x over
    localparam longint LIMIT_TIME = 80_000_000;

    typedef enum int {
        B_TEXT,
        B_EDGE,
        B_READ,
        B_MISC,
        B_NOISE
    } t_burst;

    typedef struct {
        bit                 is_cfg;
        logic [7:0]         cfg_val;
        tcw_pkg::t_in_word  word;
        bit                 has_lit;
        tcw_pkg::t_out_word lit;
    } t_stim_row;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               start      = 1'b0;
    tcw_pkg::t_in_word  i_in       = '0;
    logic               i_cfg_we   = 1'b0;
    logic [7:0]         i_cfg_data = 8'd0;
    logic               busy;
    logic               o_strobe;
    tcw_pkg::t_out_word o_out;

    // console shadow state
    logic [tcw_pkg::CELL_W-1:0] screen_model [CELLS];
    int                         cursor_model;
    logic [7:0]                 attr_model;

    tcw_pkg::t_out_word result_q [$];
    t_stim_row          stim_table [$];
    int                 mismatches = 0;
    int                 words_sent = 0;

    text_console_writer #(
        .COLUMNS(COLS),
        .ROWS   (NROWS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_in      (i_in),
        .o_strobe  (o_strobe),
        .o_out     (o_out),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++) screen_model[i] = tcw_pkg::BLANK_CELL;
        cursor_model = 0;
    endfunction

    function automatic void scroll_screen();
        for (int i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
        for (int i = CELLS - COLS; i < CELLS; i++) screen_model[i] = '0;
    endfunction

    function automatic tcw_pkg::t_out_word console_predict(tcw_pkg::t_in_word w);
        tcw_pkg::t_out_word r;
        int                 row;
        r = '0;
        r.printed = 1'b1;
        case (w.cmd)
            tcw_pkg::CMD_PUT: begin
                if (w.char_code == tcw_pkg::CHAR_NL) begin
                    // newline scrolls at the bottom, also with a wrap pending
                    row = cursor_model / COLS + 1;
                    if (row >= NROWS) begin
                        scroll_screen();
                        row = NROWS - 1;
                    end
                    cursor_model = row * COLS;
                end else begin
                    // pending wrap is taken first, even for a carriage return
                    if (cursor_model >= CELLS) begin
                        scroll_screen();
                        cursor_model = CELLS - COLS;
                    end
                    if (w.char_code == tcw_pkg::CHAR_CR) begin
                        r.printed = 1'b0;
                    end else begin
                        screen_model[cursor_model] = {attr_model, w.char_code};
                        cursor_model++;
                    end
                end
            end
            tcw_pkg::CMD_READ: begin
                if (w.cell_index < CELLS)
                    {r.cell_attr, r.cell_glyph} = screen_model[w.cell_index];
            end
            tcw_pkg::CMD_CLEAR: blank_screen();
            default: ;
        endcase
        r.cursor_pos = tcw_pkg::POS_W'(cursor_model);
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic tcw_pkg::t_in_word make_word(tcw_pkg::t_cmd_code c, logic [7:0] ch,
                                                    logic [10:0] ix);
        tcw_pkg::t_in_word w;
        w.cmd        = c;
        w.char_code  = ch;
        w.cell_index = ix;
        return w;
    endfunction

    function automatic void tab_word(tcw_pkg::t_cmd_code c, logic [7:0] ch, logic [10:0] ix);
        t_stim_row r;
        r = '{is_cfg: 1'b0, cfg_val: 8'd0, word: make_word(c, ch, ix), has_lit: 1'b0,
              lit: '0};
        stim_table.push_back(r);
    endfunction

    function automatic void tab_lit(tcw_pkg::t_cmd_code c, logic [7:0] ch, logic [10:0] ix,
                                    logic [7:0] glyph, logic [7:0] attr,
                                    logic [10:0] pos, logic prt);
        t_stim_row r;
        r.is_cfg  = 1'b0;
        r.cfg_val = 8'd0;
        r.word    = make_word(c, ch, ix);
        r.has_lit = 1'b1;
        r.lit     = '{cell_glyph: glyph, cell_attr: attr, cursor_pos: pos, printed: prt};
        stim_table.push_back(r);
    endfunction

    function automatic void tab_attr(logic [7:0] v);
        t_stim_row r;
        r = '{is_cfg: 1'b1, cfg_val: v, word: '0, has_lit: 1'b0, lit: '0};
        stim_table.push_back(r);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [7:0] pick_glyph();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == tcw_pkg::CHAR_NL || b == tcw_pkg::CHAR_CR);
        return b;
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return tcw_pkg::CHAR_NL;
        if (r < 14) return tcw_pkg::CHAR_CR;
        return 8'($urandom_range(0, 255));
    endfunction

    // hand over one word, record what it should produce, then maybe idle
    task automatic send_word(input tcw_pkg::t_in_word w, input bit has_lit,
                             input tcw_pkg::t_out_word lit, input bit quiet);
        tcw_pkg::t_out_word p;
        int                 gap;
        start <= 1'b1;
        i_in  <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
        p = console_predict(w);
        result_q.push_back(has_lit ? lit : p);
        if (w.cmd != tcw_pkg::CMD_NOP) words_sent++;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (result_q.size() != 0) @(posedge i_clk);
    endtask

    // attribute write, only with nothing in flight
    task automatic write_attr(input logic [7:0] v);
        start <= 1'b0;
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        attr_model = v;
        i_cfg_we   <= 1'b0;
    endtask

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        tcw_pkg::t_out_word want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: glyph %0d attr %0d pos %0d printed %0d",
                             o_out.cell_glyph, o_out.cell_attr, o_out.cursor_pos,
                             o_out.printed);
            end else begin
                want = result_q.pop_front();
                if (o_out.cell_glyph !== want.cell_glyph
                    || o_out.cell_attr !== want.cell_attr
                    || o_out.cursor_pos !== want.cursor_pos
                    || o_out.printed !== want.printed)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected glyph %0d attr %0d pos %0d printed %0d,",
                                  " got glyph %0d attr %0d pos %0d printed %0d"},
                                 want.cell_glyph, want.cell_attr, want.cursor_pos,
                                 want.printed, o_out.cell_glyph, o_out.cell_attr,
                                 o_out.cursor_pos, o_out.printed);
                end
            end
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        tcw_pkg::t_in_word w;
        t_burst            kind;
        int                r;
        int                n;
        int                goal;
        bit                quiet;

        blank_screen();
        attr_model = tcw_pkg::ATTR_RESET;

        // directed table: reset contents, index extremes, byte extremes, special bytes
        tab_lit(tcw_pkg::CMD_READ, 8'd0, 11'd0, 8'd32, 8'd0, 11'd0, 1'b1);
        tab_lit(tcw_pkg::CMD_READ, 8'd0, 11'd1999, 8'd32, 8'd0, 11'd0, 1'b1);
        tab_lit(tcw_pkg::CMD_READ, 8'd0, 11'd2000, 8'd0, 8'd0, 11'd0, 1'b1);   // out of range
        tab_lit(tcw_pkg::CMD_READ, 8'hFF, 11'd2047, 8'd0, 8'd0, 11'd0, 1'b1);
        tab_lit(tcw_pkg::CMD_NOP, 8'hFF, 11'd2047, 8'd0, 8'd0, 11'd0, 1'b1);
        tab_lit(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_CR, 11'd0, 8'd0, 8'd0, 11'd0, 1'b0);
        tab_lit(tcw_pkg::CMD_PUT, 8'h00, 11'd0, 8'd0, 8'd0, 11'd1, 1'b1);
        tab_lit(tcw_pkg::CMD_READ, 8'd0, 11'd0, 8'd0, tcw_pkg::ATTR_RESET, 11'd1, 1'b1);
        tab_attr(8'hFF);
        tab_lit(tcw_pkg::CMD_PUT, 8'hFF, 11'd0, 8'd0, 8'd0, 11'd2, 1'b1);
        tab_lit(tcw_pkg::CMD_READ, 8'd0, 11'd1, 8'hFF, 8'hFF, 11'd2, 1'b1);
        tab_attr(8'h00);
        tab_word(tcw_pkg::CMD_PUT, 8'h41, 11'd0);
        tab_lit(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NL, 11'd0, 8'd0, 8'd0, 11'd80, 1'b1);
        tab_word(tcw_pkg::CMD_READ, 8'd0, 11'd2);
        tab_lit(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_CR, 11'h7FF, 8'd0, 8'd0, 11'd80, 1'b0);
        tab_word(tcw_pkg::CMD_PUT, 8'h7F, 11'd0);
        tab_word(tcw_pkg::CMD_READ, 8'd0, 11'd80);
        tab_lit(tcw_pkg::CMD_CLEAR, 8'd0, 11'd0, 8'd0, 8'd0, 11'd0, 1'b1);
        tab_lit(tcw_pkg::CMD_READ, 8'd0, 11'd1, 8'd32, 8'd0, 11'd0, 1'b1);
        tab_word(tcw_pkg::CMD_PUT, 8'h80, 11'd0);
        tab_word(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NL, 11'd0);
        tab_word(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NL, 11'd0);
        tab_word(tcw_pkg::CMD_READ, 8'd0, 11'd0);
        tab_word(tcw_pkg::CMD_CLEAR, 8'hFF, 11'h7FF);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[i]) begin
            if (stim_table[i].is_cfg)
                write_attr(stim_table[i].cfg_val);
            else
                send_word(stim_table[i].word, stim_table[i].has_lit, stim_table[i].lit,
                          1'b0);
        end

        // random bursts
        goal = words_sent + RAND_WORDS;
        while (words_sent < goal) begin
            if ($urandom_range(0, 7) == 0) begin
                r = $urandom_range(0, 99);
                if (r < 25) write_attr(8'h00);
                else if (r < 50) write_attr(8'hFF);
                else write_attr(8'($urandom_range(0, 255)));
            end
            quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 35) kind = B_TEXT;
            else if (r < 55) kind = B_EDGE;
            else if (r < 78) kind = B_READ;
            else if (r < 88) kind = B_MISC;
            else kind = B_NOISE;

            case (kind)
                B_TEXT: begin
                    n = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 30);
                    repeat (n)
                        send_word(make_word(tcw_pkg::CMD_PUT, pick_text_byte(),
                                            11'($urandom_range(0, 2047))),
                                  1'b0, '0, quiet);
                end
                B_EDGE: begin
                    // walk to the last row, fill it to a pending wrap, then hit the wrap
                    if (cursor_model < CELLS) begin
                        n = (NROWS - 1) - cursor_model / COLS;
                        repeat (n)
                            send_word(make_word(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NL,
                                                11'($urandom_range(0, 2047))),
                                      1'b0, '0, quiet);
                    end
                    while (cursor_model < CELLS)
                        send_word(make_word(tcw_pkg::CMD_PUT, pick_glyph(),
                                            11'($urandom_range(0, 2047))),
                                  1'b0, '0, quiet);
                    r = $urandom_range(0, 2);
                    w = make_word(tcw_pkg::CMD_PUT,
                                  (r == 0) ? tcw_pkg::CHAR_NL
                                           : (r == 1) ? tcw_pkg::CHAR_CR : pick_glyph(),
                                  11'($urandom_range(0, 2047)));
                    send_word(w, 1'b0, '0, quiet);
                    send_word(make_word(tcw_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                                        11'($urandom_range(CELLS - 2 * COLS, CELLS - 1))),
                              1'b0, '0, quiet);
                end
                B_READ: begin
                    n = $urandom_range(1, 12);
                    repeat (n) begin
                        r = $urandom_range(0, 99);
                        if (r < 40)
                            w = make_word(tcw_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                                          11'($urandom_range(0, 2047)));
                        else if (r < 50)
                            w = make_word(tcw_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                                          11'($urandom_range(CELLS, 2047)));
                        else if (cursor_model > 0 && cursor_model <= CELLS)
                            w = make_word(tcw_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                                          11'($urandom_range(cursor_model > 16
                                                                 ? cursor_model - 16 : 0,
                                                             cursor_model - 1)));
                        else
                            w = make_word(tcw_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                                          11'($urandom_range(0, CELLS - 1)));
                        send_word(w, 1'b0, '0, quiet);
                    end
                end
                B_MISC: begin
                    w = make_word(($urandom_range(0, 1) == 0) ? tcw_pkg::CMD_CLEAR
                                                              : tcw_pkg::CMD_NOP,
                                  8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
                    send_word(w, 1'b0, '0, quiet);
                end
                default: begin
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        w.cmd        = 2'($urandom_range(0, 3));
                        w.char_code  = 8'($urandom_range(0, 255));
                        w.cell_index = 11'($urandom_range(0, 2047));
                        send_word(w, 1'b0, '0, quiet);
                    end
                end
            endcase
        end

        start <= 1'b0;
        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && result_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hang guard
    initial begin
        #(LIMIT_TIME);
        $display("simulation failed");
        $finish;
    end

endmodule
